// ----- rtl/spli_pkg.sv -----
// shared types and codes for the sorted position list insert block
// no dependencies; imported by every module of the block
`default_nettype none

package spli_pkg;

  // operation codes carried on the request tuser
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  // status codes carried on the result tuser
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 72;

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] x;
    logic [15:0] y;
  } rec_t;

  typedef struct packed {
    logic clear;
    logic probe;
    logic commit;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/sorted_position_list_insert.sv -----
// sorted position list insert: a row of CAPACITY cells kept in (y, x) order
// the result is registered at the end of the commit cycle
// a new request is taken only while idle (probe cycle, then commit cycle);
//   the commit waits while the previous result is still held on the output
// reset (rst, synchronous): count and valid bits cleared, result slot empty;
//   record payloads are not reset and are never seen before being written
`default_nettype none

module sorted_position_list_insert #(
  parameter int CAPACITY = 256
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // request stream
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [spli_pkg::IN_DATA_W-1:0]  s_tdata,  // rec_id, pos_x, pos_y, read_index
  input  wire logic [1:0]                      s_tuser,  // operation
  // result stream
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [spli_pkg::OUT_DATA_W-1:0]      m_tdata,  // placed_at, entry_count, out_id,
                                                         // out_x, out_y, zero pad
  output logic [1:0]                           m_tuser   // status
);
  import spli_pkg::*;

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  // two-state sequencer: waiting for a request, or committing one
  localparam logic S_IDLE = 1'b0;
  localparam logic S_DONE = 1'b1;

  logic            state;
  logic            state_next;

  // request held through the commit cycle
  logic [1:0]      op_q;
  rec_t            rec_q;

  logic [CW-1:0]   cnt;
  logic [CW-1:0]   cnt_next;

  // request fields unpacked
  rec_t            in_rec;
  logic [7:0]      in_idx;

  // cell row wiring
  cell_ctl_t       ctl;
  rec_t            row_rec  [CAPACITY];
  logic [CAPACITY-1:0] row_valid;
  logic [CAPACITY-1:0] row_lt;
  logic [CAPACITY-1:0] row_hit;
  logic [CAPACITY-1:0] bnd;

  logic [IW-1:0]   pos;
  rec_t            rd_rec;
  logic            rd_hit;

  logic            accept;
  logic            out_free;
  logic            advance;
  logic            full;

  logic [1:0]      status;
  logic [7:0]      placed;
  rec_t            out_rec;

  assign in_rec.id = s_tdata[15:0];
  assign in_rec.x  = s_tdata[31:16];
  assign in_rec.y  = s_tdata[47:32];
  assign in_idx    = s_tdata[55:48];

  // no request is taken while reset is held
  assign s_tready = (state == S_IDLE) && !rst;
  assign accept   = s_tvalid && s_tready;
  // result slot can take a new result this cycle
  assign out_free = !m_tvalid || m_tready;
  assign advance  = (state == S_DONE) && out_free;
  assign full     = (cnt == CW'(CAPACITY));

  // cells compare in the accept cycle and commit once the result slot is free
  assign ctl.probe  = accept;
  assign ctl.commit = advance && (op_q == OP_INSERT) && !full;
  assign ctl.clear  = advance && (op_q == OP_CLEAR);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_head
      // the head cell has no lower neighbor: it is tied off as if one sorted below it
      spli_cell #(.IDX(i)) u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctl        (ctl),
        .probe_rec  (in_rec),
        .read_index (in_idx),
        .ins_rec    (rec_q),
        .prev_lt    (1'b1),
        .prev_valid (1'b1),
        .prev_rec   (rec_q),
        .rec        (row_rec[i]),
        .valid      (row_valid[i]),
        .lt         (row_lt[i]),
        .hit        (row_hit[i])
      );
    end else begin : g_body
      spli_cell #(.IDX(i)) u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctl        (ctl),
        .probe_rec  (in_rec),
        .read_index (in_idx),
        .ins_rec    (rec_q),
        .prev_lt    (row_lt[i-1]),
        .prev_valid (row_valid[i-1]),
        .prev_rec   (row_rec[i-1]),
        .rec        (row_rec[i]),
        .valid      (row_valid[i]),
        .lt         (row_lt[i]),
        .hit        (row_hit[i])
      );
    end
  end

  // the lt bits form a prefix, so the insert point is its single falling edge
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (i == 0) bnd[i] = !row_lt[i];
      else        bnd[i] = !row_lt[i] && row_lt[i-1];
    end
  end

  spli_collect #(.N(CAPACITY), .IW(IW)) u_collect (
    .bnd    (bnd),
    .hit    (row_hit),
    .recs   (row_rec),
    .pos    (pos),
    .rd_rec (rd_rec),
    .rd_hit (rd_hit)
  );

  // result fields for the request being committed
  always_comb begin
    status   = ST_OK;
    placed   = '0;
    out_rec  = '0;
    cnt_next = cnt;
    case (op_q)
      OP_CLEAR: begin
        cnt_next = '0;
      end
      OP_INSERT: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          placed   = 8'(pos);
          cnt_next = cnt + CW'(1);
        end
      end
      OP_READ: begin
        if (rd_hit) out_rec = rd_rec;
        else        status  = ST_RANGE;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (accept)  state_next = S_DONE;
      S_DONE:  if (advance) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (advance) begin
        cnt      <= cnt_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // request and result payloads
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q  <= s_tuser;
      rec_q <= in_rec;
    end
    if (advance) begin
      m_tuser <= status;
      m_tdata <= {7'd0, out_rec.y, out_rec.x, out_rec.id, 9'(cnt_next), placed};
    end
  end

`ifndef NO_ASSERTIONS
  // count never passes the table size
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(CAPACITY))
    else $error("record count above capacity");

  // valid bits in the row track the count exactly
  a_valid_cnt: assert property (@(posedge clk) disable iff (rst)
    $countones(row_valid) == 32'(cnt))
    else $error("valid cells disagree with count");

  // at most one insert point while committing
  a_bnd_onehot: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |-> $onehot0(bnd))
    else $error("more than one insert point");

  // an accepted request always moves to the commit cycle
  a_accept_done: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_DONE))
    else $error("accepted request not committed");
`endif

endmodule

`default_nettype wire

// ----- rtl/spli_cell.sv -----
// one table slot: holds a record and its valid bit, compares against a probe
// and takes its neighbor's record on an insert; depends on spli_pkg
`default_nettype none

module spli_cell #(
  parameter int IDX = 0
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire spli_pkg::cell_ctl_t ctl,
  input  wire spli_pkg::rec_t    probe_rec,
  input  wire logic [7:0]        read_index,
  input  wire spli_pkg::rec_t    ins_rec,
  input  wire logic              prev_lt,
  input  wire logic              prev_valid,
  input  wire spli_pkg::rec_t    prev_rec,
  output spli_pkg::rec_t         rec,
  output logic                   valid,
  output logic                   lt,
  output logic                   hit
);
  import spli_pkg::*;

  logic key_less;

  // stored key strictly below the probe key, y first then x
  assign key_less = (rec.y < probe_rec.y) ||
                    ((rec.y == probe_rec.y) && (rec.x < probe_rec.x));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      lt    <= 1'b0;
      hit   <= 1'b0;
    end else begin
      if (ctl.probe) begin
        lt  <= valid && key_less;
        hit <= valid && (32'(read_index) == IDX);
      end
      if (ctl.clear) begin
        valid <= 1'b0;
      end else if (ctl.commit) begin
        valid <= valid | prev_valid;
      end
    end
  end

  // records below the insert point stay, the boundary takes the new one,
  // everything above shifts up by one
  always_ff @(posedge clk) begin
    if (ctl.commit && !lt) begin
      rec <= prev_lt ? ins_rec : prev_rec;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/spli_collect.sv -----
// gathers the row outputs: encodes the insert point and picks the read record
// depends on spli_pkg
`default_nettype none

module spli_collect #(
  parameter int N  = 256,
  parameter int IW = 8
) (
  input  wire logic [N-1:0]    bnd,
  input  wire logic [N-1:0]    hit,
  input  wire spli_pkg::rec_t  recs [N],
  output logic [IW-1:0]        pos,
  output spli_pkg::rec_t       rd_rec,
  output logic                 rd_hit
);
  import spli_pkg::*;

  // both inputs are one-hot or empty, so an and-or tree suffices
  always_comb begin
    pos    = '0;
    rd_rec = '0;
    for (int i = 0; i < N; i++) begin
      if (bnd[i]) pos = pos | IW'(i);
      if (hit[i]) rd_rec = rd_rec | recs[i];
    end
  end

  assign rd_hit = |hit;

endmodule

`default_nettype wire
